>>> hdl/mandelbrot_escape_time_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Mandelbrot escape-time core
// Implication checks sampled on the rising clock, off while reset is held.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH

// same-cycle implication
`define MET_ASSERT_IMP(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MET_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/met_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_pkg
// Widths, constants, token types and saturation for the escape-time core.
// ----------------------------------------------------------------------------
package met_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 28;
	localparam int ITER_WIDTH  = 16;
	localparam int COLOR_WIDTH = 8;
	localparam int NUM_CELLS   = 2;

	localparam int PROD_WIDTH = 2 * COORD_WIDTH;
	localparam int SQ_WIDTH   = PROD_WIDTH - FRAC_BITS;
	localparam int SUM_WIDTH  = SQ_WIDTH + 2;

	localparam logic [COLOR_WIDTH-1:0] COLOR_INSIDE = COLOR_WIDTH'(255);
	localparam logic [COLOR_WIDTH-1:0] MOD_LAST     = COLOR_WIDTH'(254);
	localparam logic [ITER_WIDTH-1:0]  MAX_ITER_RST = ITER_WIDTH'(10000);

	localparam logic [SQ_WIDTH:0] ESCAPE_LIMIT = (SQ_WIDTH + 1)'(1) << (FRAC_BITS + 2);

	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX =
		{{(SUM_WIDTH - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN =
		{{(SUM_WIDTH - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

	typedef struct packed {
		logic                          live;
		logic                          fin;
		logic                          esc;
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] cr;
		logic signed [COORD_WIDTH-1:0] ci;
		logic [ITER_WIDTH-1:0]         iter;
		logic [COLOR_WIDTH-1:0]        rem;
	} token_t;

	typedef struct packed {
		logic                          live;
		logic                          fin;
		logic                          esc;
		logic signed [PROD_WIDTH-1:0]  xx;
		logic signed [PROD_WIDTH-1:0]  yy;
		logic signed [PROD_WIDTH-1:0]  xy;
		logic signed [COORD_WIDTH-1:0] cr;
		logic signed [COORD_WIDTH-1:0] ci;
		logic [ITER_WIDTH-1:0]         iter;
		logic [COLOR_WIDTH-1:0]        rem;
	} mid_t;

	function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
		input logic signed [SUM_WIDTH-1:0] v
	);
		logic signed [COORD_WIDTH-1:0] r;
		if (v > SUM_MAX) begin
			r = SUM_MAX[COORD_WIDTH-1:0];
		end else if (v < SUM_MIN) begin
			r = SUM_MIN[COORD_WIDTH-1:0];
		end else begin
			r = v[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/met_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_cell
// One iteration round in two register stages: squares and cross product,
// then escape test, update of z with saturation, and round count.
// ----------------------------------------------------------------------------
module met_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [met_pkg::ITER_WIDTH-1:0]       max_iter,
	input  met_pkg::token_t                      tok_i,
	output met_pkg::token_t                      tok_o
);

	localparam int W  = met_pkg::COORD_WIDTH;
	localparam int PW = met_pkg::PROD_WIDTH;
	localparam int SW = met_pkg::SQ_WIDTH;
	localparam int UW = met_pkg::SUM_WIDTH;

	logic signed [W-1:0]  x_d;
	logic signed [W-1:0]  y_d;
	logic signed [PW-1:0] xx_d;
	logic signed [PW-1:0] yy_d;
	logic signed [PW-1:0] xy_d;
	met_pkg::mid_t        mid_d;
	met_pkg::mid_t        mid_s1;
	logic                 live_s1;

	logic [SW-1:0]        x2;
	logic [SW-1:0]        y2;
	logic [SW:0]          sum_sq;
	logic                 escape;
	logic signed [UW-1:0] diff;
	logic signed [UW-1:0] re_sum;
	logic signed [PW-1:0] xy_full;
	logic signed [PW-1:0] xy_sh;
	logic signed [UW-1:0] im_sum;
	met_pkg::token_t      nxt;
	met_pkg::token_t      tok_s2;
	logic                 live_s2;

	assign x_d  = tok_i.x;
	assign y_d  = tok_i.y;
	assign xx_d = x_d * x_d;
	assign yy_d = y_d * y_d;
	assign xy_d = x_d * y_d;

	always_comb begin
		mid_d.live = tok_i.live;
		mid_d.fin  = tok_i.fin | (tok_i.iter >= max_iter);
		mid_d.esc  = tok_i.esc;
		mid_d.xx   = xx_d;
		mid_d.yy   = yy_d;
		mid_d.xy   = xy_d;
		mid_d.cr   = tok_i.cr;
		mid_d.ci   = tok_i.ci;
		mid_d.iter = tok_i.iter;
		mid_d.rem  = tok_i.rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
		end else begin
			live_s1 <= tok_i.live;
		end
	end

	always_ff @(posedge clk) begin
		mid_s1 <= mid_d;
	end

	assign x2      = mid_s1.xx[PW-1:met_pkg::FRAC_BITS];
	assign y2      = mid_s1.yy[PW-1:met_pkg::FRAC_BITS];
	assign sum_sq  = {1'b0, x2} + {1'b0, y2};
	assign escape  = sum_sq > met_pkg::ESCAPE_LIMIT;
	assign diff    = $signed({2'b00, x2}) - $signed({2'b00, y2});
	assign re_sum  = diff + $signed({{(UW - W){mid_s1.cr[W-1]}}, mid_s1.cr});
	assign xy_full = mid_s1.xy;
	assign xy_sh   = xy_full >>> (met_pkg::FRAC_BITS - 1);
	assign im_sum  = $signed(xy_sh[UW-1:0])
		+ $signed({{(UW - W){mid_s1.ci[W-1]}}, mid_s1.ci});

	always_comb begin
		nxt.live = live_s1;
		nxt.fin  = 1'b0;
		nxt.esc  = 1'b0;
		nxt.x    = met_pkg::sat_coord(re_sum);
		nxt.y    = met_pkg::sat_coord(im_sum);
		nxt.cr   = mid_s1.cr;
		nxt.ci   = mid_s1.ci;
		nxt.iter = mid_s1.iter + met_pkg::ITER_WIDTH'(1);
		nxt.rem  = (mid_s1.rem == met_pkg::MOD_LAST) ? '0
			: mid_s1.rem + met_pkg::COLOR_WIDTH'(1);
		if (mid_s1.fin) begin
			nxt.fin  = 1'b1;
			nxt.esc  = mid_s1.esc;
			nxt.iter = mid_s1.iter;
			nxt.rem  = mid_s1.rem;
		end else if (escape) begin
			nxt.fin  = 1'b1;
			nxt.esc  = 1'b1;
			nxt.iter = mid_s1.iter;
			nxt.rem  = mid_s1.rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s2 <= 1'b0;
		end else begin
			live_s2 <= live_s1;
		end
	end

	always_ff @(posedge clk) begin
		tok_s2 <= nxt;
	end

	always_comb begin
		tok_o      = tok_s2;
		tok_o.live = live_s2;
	end

endmodule

>>> hdl/mandelbrot_escape_time_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Escape-time count of one point c in signed Q4.28 on a ring of round cells.
//
// Input: c_real and c_imag are taken at a rising edge with start high and
// busy low. One point is in flight at a time; busy stays high until its word
// is delivered. Output: color is valid for one cycle with done high. Nothing
// can hold it off, and busy drops at the edge that raises done, so the next
// start can be taken while done is high.
// Config: cfg_data loads max_iter when cfg_valid and cfg_ready are high;
// cfg_ready is low while busy or start is high.
// Structure: a ring of 2 cells, each a multiplier stage and an add/compare
// stage. The point leaves only at the end of a pass; it evaluates
// escape round + 1 rounds, or max_iter + 1 rounds if it does not escape.
// Reset: max_iter returns to 10000 and any point in flight is dropped.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_core_assert.svh"

module mandelbrot_escape_time_core (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic signed [met_pkg::COORD_WIDTH-1:0]    c_real,
	input  logic signed [met_pkg::COORD_WIDTH-1:0]    c_imag,
	output logic                                      done,
	output logic [met_pkg::COLOR_WIDTH-1:0]           color,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [met_pkg::ITER_WIDTH-1:0]            cfg_data
);

	localparam int NC = met_pkg::NUM_CELLS;

	logic [met_pkg::ITER_WIDTH-1:0]  max_iter_q;
	logic                            busy_q;
	logic                            done_q;
	logic [met_pkg::COLOR_WIDTH-1:0] color_q;
	logic                            accept;
	logic                            emit;
	met_pkg::token_t                 feed;
	met_pkg::token_t                 tok_in  [NC];
	met_pkg::token_t                 tok_out [NC];
	logic [NC-1:0]                   live_vec;

	assign accept    = start && !busy_q;
	assign emit      = tok_out[NC-1].live && tok_out[NC-1].fin;
	assign cfg_ready = !busy_q && !start;

	always_comb begin
		feed = tok_out[NC-1];
		if (accept) begin
			feed.live = 1'b1;
			feed.fin  = 1'b0;
			feed.esc  = 1'b0;
			feed.x    = '0;
			feed.y    = '0;
			feed.cr   = c_real;
			feed.ci   = c_imag;
			feed.iter = '0;
			feed.rem  = '0;
		end else if (emit) begin
			feed.live = 1'b0;
		end
	end

	assign tok_in[0] = feed;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		if (k > 0) begin : g_link
			assign tok_in[k] = tok_out[k-1];
		end
		met_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.max_iter (max_iter_q),
			.tok_i    (tok_in[k]),
			.tok_o    (tok_out[k])
		);
		assign live_vec[k] = tok_out[k].live;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= met_pkg::MAX_ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_iter_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (emit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			color_q <= tok_out[NC-1].esc ? tok_out[NC-1].rem : met_pkg::COLOR_INSIDE;
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign color = color_q;

	`MET_ASSERT_IMP(a_single_token, clk, arst_n, 1'b1, $countones(live_vec) <= 1)
	`MET_ASSERT_IMP(a_idle_empty, clk, arst_n, !busy_q, live_vec == '0)
	`MET_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy_q)
	`MET_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy_q)

endmodule
